>>> sv/edge_latched_interrupt_controller_defines.svh
// Assertion macros shared by the interrupt controller RTL.
`ifndef EDGE_LATCHED_INTERRUPT_CONTROLLER_DEFINES_SVH
`define EDGE_LATCHED_INTERRUPT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ELIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ELIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/elic_pkg.sv
// Types and register map constants for the edge-latched interrupt controller.
package elic_pkg;

  localparam int BANK_BITS = 32;
  localparam int BANKS     = 2;
  localparam int WAKE_REGS = 4;

  typedef logic [1:0]           mode_t;
  typedef logic [7:0]           offset_t;
  typedef logic [BANK_BITS-1:0] word_t;
  typedef logic [5:0]           source_t;

  // Request kinds.
  localparam mode_t MODE_READ  = 2'd0;
  localparam mode_t MODE_WRITE = 2'd1;
  localparam mode_t MODE_RAISE = 2'd2;
  localparam mode_t MODE_LOWER = 2'd3;

  // Register map, byte offsets.
  localparam offset_t OFF_TEST0     = 8'h00;
  localparam offset_t OFF_TEST1     = 8'h04;
  localparam offset_t OFF_ENABLE0   = 8'h08;
  localparam offset_t OFF_ENABLE1   = 8'h0C;
  localparam offset_t OFF_POL0      = 8'h10;
  localparam offset_t OFF_POL1      = 8'h14;
  localparam offset_t OFF_TEST_SEL  = 8'h18;
  localparam offset_t OFF_STATUS0   = 8'h1C;
  localparam offset_t OFF_STATUS1   = 8'h20;
  localparam offset_t OFF_SET0      = 8'h24;
  localparam offset_t OFF_SET1      = 8'h28;
  localparam offset_t OFF_WAKE_EN0  = 8'h2C;
  localparam offset_t OFF_WAKE_EN1  = 8'h30;
  localparam offset_t OFF_WAKE_POL0 = 8'h34;
  localparam offset_t OFF_WAKE_POL1 = 8'h38;
  localparam offset_t OFF_LAST      = OFF_WAKE_POL1;

endpackage

>>> sv/elic_if.sv
// Request and response channel interfaces of the interrupt controller.
interface elic_req_if;
  logic                 valid;
  logic                 ready;
  elic_pkg::mode_t      mode;
  elic_pkg::offset_t    access_offset;
  elic_pkg::word_t      write_data;
  elic_pkg::source_t    source_number;

  modport source (output valid, output mode, output access_offset,
                  output write_data, output source_number, input ready);
  modport sink (input valid, input mode, input access_offset,
                input write_data, input source_number, output ready);
endinterface

interface elic_rsp_if;
  logic            valid;
  logic            ready;
  elic_pkg::word_t read_data;
  logic            irq_level;
  logic            pulse_low;
  logic            bad_access;

  modport source (output valid, output read_data, output irq_level,
                  output pulse_low, output bad_access, input ready);
  modport sink (input valid, input read_data, input irq_level,
                input pulse_low, input bad_access, output ready);
endinterface

>>> sv/edge_latched_interrupt_controller.sv
// Edge-latched interrupt controller: 64 sources in two banks of 32.
//
// The req channel carries one request per handshake: a bus read, a bus
// write, a source line raised or a source line lowered. The rsp channel
// returns exactly one response per request, in order, with read data, the
// cascade IRQ level after the request, a pulse-low flag for status clears
// and a flag for unsupported offsets.
// A request accepted at a rising edge sits in the input register until an
// edge at which the response register is free or drains; it is processed at
// that edge and its response is valid right after it. One request is accepted
// every cycle while responses are taken; the rate is set by the single pass
// from the input register to the response register.
// When the response is not taken, the response register holds it and the
// input register can still take one more request; after that, req.ready
// stays low until the response drains.
// Synchronous reset clears every controller register to zero and empties
// both the input and the response registers.
`include "edge_latched_interrupt_controller_defines.svh"

module edge_latched_interrupt_controller (
  input logic         clk,
  input logic         rst,
  elic_req_if.sink    req,
  elic_rsp_if.source  rsp
);

  // Input register.
  logic                s1_valid;
  elic_pkg::mode_t     s1_mode;
  elic_pkg::offset_t   s1_offset;
  elic_pkg::word_t     s1_data;
  elic_pkg::source_t   s1_source;
  logic                advance;

  // Controller state.
  logic [elic_pkg::BANKS-1:0][elic_pkg::BANK_BITS-1:0]     raw_lines;
  logic [elic_pkg::BANKS-1:0][elic_pkg::BANK_BITS-1:0]     edge_detect;
  logic [elic_pkg::BANKS-1:0][elic_pkg::BANK_BITS-1:0]     test_regs;
  logic [elic_pkg::BANKS-1:0][elic_pkg::BANK_BITS-1:0]     enable_mask;
  logic [elic_pkg::BANKS-1:0][elic_pkg::BANK_BITS-1:0]     polarity_mask;
  logic [elic_pkg::BANKS-1:0][elic_pkg::BANK_BITS-1:0]     pending_status;
  logic [elic_pkg::WAKE_REGS-1:0][elic_pkg::BANK_BITS-1:0] wake_regs;
  elic_pkg::word_t                                         test_select;

  logic [elic_pkg::BANKS-1:0][elic_pkg::BANK_BITS-1:0]     raw_lines_next;
  logic [elic_pkg::BANKS-1:0][elic_pkg::BANK_BITS-1:0]     edge_detect_next;
  logic [elic_pkg::BANKS-1:0][elic_pkg::BANK_BITS-1:0]     test_regs_next;
  logic [elic_pkg::BANKS-1:0][elic_pkg::BANK_BITS-1:0]     enable_mask_next;
  logic [elic_pkg::BANKS-1:0][elic_pkg::BANK_BITS-1:0]     polarity_mask_next;
  logic [elic_pkg::BANKS-1:0][elic_pkg::BANK_BITS-1:0]     pending_status_next;
  logic [elic_pkg::WAKE_REGS-1:0][elic_pkg::BANK_BITS-1:0] wake_regs_next;
  elic_pkg::word_t                                         test_select_next;

  // Response values computed from the input register.
  elic_pkg::word_t     read_data_next;
  logic                irq_level_next;
  logic                pulse_low_next;
  logic                bad_access_next;

  // Response register.
  logic                out_valid;
  elic_pkg::word_t     out_read_data;
  logic                out_irq_level;
  logic                out_pulse_low;
  logic                out_bad_access;

  // Level implied by the current state, used for checking.
  logic                irq_state;

  // The input register moves on when the response register is free or drains.
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_read_data;
  assign rsp.irq_level  = out_irq_level;
  assign rsp.pulse_low  = out_pulse_low;
  assign rsp.bad_access = out_bad_access;

  assign irq_state = |((pending_status[0] & enable_mask[0]) |
                       (pending_status[1] & enable_mask[1]));

  // Request processing: one pass over the current state.
  always_comb begin
    elic_pkg::word_t bit_sel;
    elic_pkg::word_t level;
    logic            bank;

    raw_lines_next      = raw_lines;
    edge_detect_next    = edge_detect;
    test_regs_next      = test_regs;
    enable_mask_next    = enable_mask;
    polarity_mask_next  = polarity_mask;
    pending_status_next = pending_status;
    wake_regs_next      = wake_regs;
    test_select_next    = test_select;
    read_data_next      = '0;
    pulse_low_next      = 1'b0;
    bad_access_next     = 1'b0;
    bit_sel             = elic_pkg::word_t'(1) << s1_source[4:0];
    bank                = s1_source[5];
    level               = '0;

    if (s1_mode == elic_pkg::MODE_RAISE || s1_mode == elic_pkg::MODE_LOWER) begin
      // Raise or lower raw line, re-run edge latch; a raise also sets pending.
      if (s1_mode == elic_pkg::MODE_RAISE) begin
        raw_lines_next[bank] = raw_lines[bank] | bit_sel;
      end else begin
        raw_lines_next[bank] = raw_lines[bank] & ~bit_sel;
      end
      level = raw_lines_next[bank] ^ polarity_mask[bank];
      pending_status_next[bank] = pending_status[bank] | (level & ~edge_detect[bank]);
      edge_detect_next[bank] = level;
      if (s1_mode == elic_pkg::MODE_RAISE) begin
        pending_status_next[bank] = pending_status_next[bank] | bit_sel;
      end
    end else if (s1_offset[1:0] != 2'b00 || s1_offset > elic_pkg::OFF_LAST) begin
      bad_access_next = 1'b1;
    end else if (s1_mode == elic_pkg::MODE_READ) begin
      // Register read; set offsets read as zero.
      case (s1_offset)
        elic_pkg::OFF_TEST0:     read_data_next = test_regs[0];
        elic_pkg::OFF_TEST1:     read_data_next = test_regs[1];
        elic_pkg::OFF_ENABLE0:   read_data_next = enable_mask[0];
        elic_pkg::OFF_ENABLE1:   read_data_next = enable_mask[1];
        elic_pkg::OFF_POL0:      read_data_next = polarity_mask[0];
        elic_pkg::OFF_POL1:      read_data_next = polarity_mask[1];
        elic_pkg::OFF_TEST_SEL:  read_data_next = test_select;
        elic_pkg::OFF_STATUS0:   read_data_next = pending_status[0];
        elic_pkg::OFF_STATUS1:   read_data_next = pending_status[1];
        elic_pkg::OFF_WAKE_EN0:  read_data_next = wake_regs[0];
        elic_pkg::OFF_WAKE_EN1:  read_data_next = wake_regs[1];
        elic_pkg::OFF_WAKE_POL0: read_data_next = wake_regs[2];
        elic_pkg::OFF_WAKE_POL1: read_data_next = wake_regs[3];
        default:                 read_data_next = '0;
      endcase
    end else begin
      // Register write; a polarity write re-runs that bank's edge latch.
      case (s1_offset)
        elic_pkg::OFF_TEST0:    test_regs_next[0] = s1_data;
        elic_pkg::OFF_TEST1:    test_regs_next[1] = s1_data;
        elic_pkg::OFF_ENABLE0:  enable_mask_next[0] = s1_data;
        elic_pkg::OFF_ENABLE1:  enable_mask_next[1] = s1_data;
        elic_pkg::OFF_POL0: begin
          polarity_mask_next[0] = s1_data;
          level = raw_lines[0] ^ s1_data;
          pending_status_next[0] = pending_status[0] | (level & ~edge_detect[0]);
          edge_detect_next[0] = level;
        end
        elic_pkg::OFF_POL1: begin
          polarity_mask_next[1] = s1_data;
          level = raw_lines[1] ^ s1_data;
          pending_status_next[1] = pending_status[1] | (level & ~edge_detect[1]);
          edge_detect_next[1] = level;
        end
        elic_pkg::OFF_TEST_SEL: test_select_next = s1_data;
        elic_pkg::OFF_STATUS0: begin
          pending_status_next[0] = pending_status[0] & ~s1_data;
          pulse_low_next = 1'b1;
        end
        elic_pkg::OFF_STATUS1: begin
          pending_status_next[1] = pending_status[1] & ~s1_data;
          pulse_low_next = 1'b1;
        end
        elic_pkg::OFF_SET0:      pending_status_next[0] = pending_status[0] | s1_data;
        elic_pkg::OFF_SET1:      pending_status_next[1] = pending_status[1] | s1_data;
        elic_pkg::OFF_WAKE_EN0:  wake_regs_next[0] = s1_data;
        elic_pkg::OFF_WAKE_EN1:  wake_regs_next[1] = s1_data;
        elic_pkg::OFF_WAKE_POL0: wake_regs_next[2] = s1_data;
        elic_pkg::OFF_WAKE_POL1: wake_regs_next[3] = s1_data;
        default:                 wake_regs_next = wake_regs;
      endcase
    end

    irq_level_next = |((pending_status_next[0] & enable_mask_next[0]) |
                       (pending_status_next[1] & enable_mask_next[1]));
  end

  // Valid flags and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      raw_lines      <= '0;
      edge_detect    <= '0;
      test_regs      <= '0;
      enable_mask    <= '0;
      polarity_mask  <= '0;
      pending_status <= '0;
      wake_regs      <= '0;
      test_select    <= '0;
    end else begin
      if (req.valid && req.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid      <= 1'b1;
        raw_lines      <= raw_lines_next;
        edge_detect    <= edge_detect_next;
        test_regs      <= test_regs_next;
        enable_mask    <= enable_mask_next;
        polarity_mask  <= polarity_mask_next;
        pending_status <= pending_status_next;
        wake_regs      <= wake_regs_next;
        test_select    <= test_select_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and response payload registers.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_mode   <= req.mode;
      s1_offset <= req.access_offset;
      s1_data   <= req.write_data;
      s1_source <= req.source_number;
    end
    if (advance) begin
      out_read_data  <= read_data_next;
      out_irq_level  <= irq_level_next;
      out_pulse_low  <= pulse_low_next;
      out_bad_access <= bad_access_next;
    end
  end

  // A held response always reports the level of the state it left behind.
  `ELIC_ASSERT_NOW(a_irq_matches_state, out_valid, out_irq_level == irq_state,
                   "response IRQ level differs from controller state")

  // An unsupported offset gives no data and no pulse.
  `ELIC_ASSERT_NOW(a_bad_is_quiet, out_valid && out_bad_access,
                   out_read_data == '0 && !out_pulse_low,
                   "bad access response carries data or pulse")

  // An unsupported offset leaves the register state untouched.
  `ELIC_ASSERT_NEXT(a_bad_keeps_state, advance && bad_access_next,
                    $stable(pending_status) && $stable(enable_mask) &&
                    $stable(polarity_mask) && $stable(edge_detect),
                    "bad access changed controller state")

  // A request waiting in the input register is not dropped.
  `ELIC_ASSERT_NEXT(a_s1_holds, s1_valid && !advance, s1_valid,
                    "stalled request lost from input register")

endmodule
